>>> src/srh_pkg.sv
// ---------------------------------------------------------------------------
// srh_pkg: shared definitions of the substring rolling hash core
// Field widths, register map and arithmetic constants used by the core,
// its port checker and the verification checker and test.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package srh_pkg;

  // Field widths of one input item and one result item.
  localparam int POS_W    = 11;
  localparam int LETTER_W = 5;
  localparam int BASE_W   = 30;
  localparam int HASH_W   = 61;

  // Width used to compare positions against the effective string length.
  // It holds any store depth up to 65536.
  localparam int LEN_W = 17;

  // Stream payload widths, padded to whole bytes.
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 64;

  // Configuration port.
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  // Register index, taken from paddr[2].
  localparam logic REG_BASE   = 1'b0;
  localparam logic REG_LENGTH = 1'b1;

  // Item kinds carried in in_tuser.
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic [HASH_W-1:0] HASH_MOD   = {HASH_W{1'b1}};
  localparam logic [BASE_W-1:0] BASE_RESET = 30'd414123123;

endpackage : srh_pkg

`default_nettype wire

>>> src/substring_rolling_hash_core.sv
// ---------------------------------------------------------------------------
// substring_rolling_hash_core: polynomial hash of substrings mod 2^61-1
// Stores a string of letters and answers range queries with the hash
// sum of (letter+1)*base^(end-1-i) over [start,end), modulo 2^61-1.
// ---------------------------------------------------------------------------
//
//   Channel  Direction  Transfer                       Payload
//   in_      slave      in_tvalid & in_tready          tuser kind, tdata pos/end/letter
//   out_     master     out_tvalid & out_tready        tuser range_error, tdata hash
//   cfg_     APB slave  psel & penable & pwrite        hash_base @0x0, string_length @0x4
//
// Writes can follow each other in every cycle while the input is ready.
// A query passes through the MUL_LO, MUL_HI and REDUCE states for every letter,
// then through DONE, which loads the output register and raises out_tvalid; a bad
// or empty range goes straight to DONE. The per-letter steps are set by
// the single 31x30 multiplier, used twice per Horner step, and the mod fold.
// The input is not ready while a query is being computed, nor while a
// finished result waits for the output register to free up.
// Reset (rst_n low, synchronous) returns the sequencer to idle, empties the
// output register and restores the registers; the letter memory is not cleared.
//
`timescale 1ns / 1ps
`default_nettype none

module substring_rolling_hash_core
  import srh_pkg::*;
#(
  parameter int MAX_LENGTH = 1024
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // Input stream.
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // [10:0] position, [21:11] range_end,
                                                  // [26:22] letter, [31:27] zero
  input  wire logic                   in_tuser,   // [0] kind
  // Result stream.
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic      [OUT_TDATA_W-1:0] out_tdata,  // [60:0] hash_value, [63:61] zero
  output logic                        out_tuser,  // [0] range_error
  // Configuration port.
  input  wire logic                   cfg_psel,
  input  wire logic                   cfg_penable,
  input  wire logic                   cfg_pwrite,
  input  wire logic [CFG_AW-1:0]      cfg_paddr,
  input  wire logic [CFG_DW-1:0]      cfg_pwdata,
  output logic      [CFG_DW-1:0]      cfg_prdata,
  output logic                        cfg_pready
);

  localparam int AW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_REDUCE,
    ST_DONE
  } state_t;

  // Input fields.
  logic [POS_W-1:0]    in_pos;
  logic [POS_W-1:0]    in_end;
  logic [LETTER_W-1:0] in_letter;

  assign in_pos    = in_tdata[POS_W-1:0];
  assign in_end    = in_tdata[2*POS_W-1:POS_W];
  assign in_letter = in_tdata[2*POS_W+LETTER_W-1:2*POS_W];

  // Registers.
  state_t              state_r,     state_nxt;
  logic [BASE_W-1:0]   base_r,      base_nxt;
  logic [POS_W-1:0]    len_r,       len_nxt;
  logic [POS_W-1:0]    idx_r,       idx_nxt;
  logic [POS_W-1:0]    end_r,       end_nxt;
  logic [HASH_W-1:0]   h_r,         h_nxt;
  logic [HASH_W:0]     acc_r,       acc_nxt;
  logic [HASH_W-1:0]   mul_r,       mul_nxt;
  logic                err_r,       err_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [HASH_W-1:0]   out_hash_r,  out_hash_nxt;
  logic                out_err_r,   out_err_nxt;

  // Effective string length: string_length saturated to the store depth.
  logic [LEN_W-1:0] len_eff;
  assign len_eff = (LEN_W'(len_r) > LEN_W'(MAX_LENGTH)) ? LEN_W'(MAX_LENGTH)
                                                        : LEN_W'(len_r);

  logic in_xfer, out_xfer, cfg_wr;
  assign in_xfer  = in_tvalid & in_tready;
  assign out_xfer = out_valid_r & out_tready;
  assign cfg_wr   = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  // Letter memory: written straight from the input on a write transfer,
  // read at the running query index.
  logic                ram_we;
  logic [LETTER_W-1:0] ram_rdata;

  assign ram_we = in_xfer && (in_tuser == KIND_WRITE) && (LEN_W'(in_pos) < len_eff);

  srh_ram #(
    .WIDTH (LETTER_W),
    .DEPTH (MAX_LENGTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(in_pos)),
    .wdata (in_letter),
    .raddr (AW'(idx_r)),
    .rdata (ram_rdata)
  );

  // Shared multiplier: the low 31 bits of h times the base in MUL_LO, the
  // high 30 bits in MUL_HI. Each product is registered before it is used.
  logic [30:0]       mul_a;
  logic [HASH_W-1:0] mul_p;

  assign mul_a = (state_r == ST_MUL_LO) ? h_r[30:0] : {1'b0, h_r[HASH_W-1:31]};
  assign mul_p = HASH_W'(mul_a) * HASH_W'(base_r);

  // Mod 2^61-1 reduction. With x = hi*base, hi*2^31*base = (x>>30) +
  // (x mod 2^30)*2^31 modulo 2^61-1, since 2^61 wraps to 1. The sum stays
  // below 2^63, so one fold and one conditional subtract finish the job.
  logic [HASH_W+1:0] red_sum;
  logic [HASH_W:0]   red_fold;
  logic [HASH_W-1:0] red_out;

  assign red_sum  = (HASH_W+2)'(acc_r) + (HASH_W+2)'(mul_r[HASH_W-1:30])
                  + {2'b00, mul_r[29:0], 31'd0};
  assign red_fold = (HASH_W+1)'(red_sum[HASH_W+1:HASH_W]) + {1'b0, red_sum[HASH_W-1:0]};
  assign red_out  = (red_fold >= {1'b0, HASH_MOD}) ? HASH_W'(red_fold - {1'b0, HASH_MOD})
                                                   : red_fold[HASH_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    base_nxt      = base_r;
    len_nxt       = len_r;
    idx_nxt       = idx_r;
    end_nxt       = end_r;
    h_nxt         = h_r;
    acc_nxt       = acc_r;
    mul_nxt       = mul_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r;
    out_hash_nxt  = out_hash_r;
    out_err_nxt   = out_err_r;

    if (out_xfer) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_BASE:   base_nxt = cfg_pwdata[BASE_W-1:0];
        REG_LENGTH: len_nxt  = cfg_pwdata[POS_W-1:0];
        default:    ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_xfer && (in_tuser == KIND_QUERY)) begin
          idx_nxt = in_pos;
          end_nxt = in_end;
          h_nxt   = '0;
          if ((in_pos > in_end) || (LEN_W'(in_end) > len_eff)) begin
            err_nxt   = 1'b1;
            state_nxt = ST_DONE;
          end else if (in_pos == in_end) begin
            err_nxt   = 1'b0;
            state_nxt = ST_DONE;
          end else begin
            err_nxt   = 1'b0;
            state_nxt = ST_MUL_LO;
          end
        end
      end
      ST_MUL_LO: begin
        mul_nxt   = mul_p;
        state_nxt = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        // The letter read issued during MUL_LO is valid now.
        acc_nxt   = (HASH_W+1)'(mul_r) + (HASH_W+1)'(ram_rdata) + (HASH_W+1)'(1);
        mul_nxt   = mul_p;
        state_nxt = ST_REDUCE;
      end
      ST_REDUCE: begin
        h_nxt   = red_out;
        idx_nxt = idx_r + POS_W'(1);
        if (idx_r + POS_W'(1) == end_r) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_MUL_LO;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_hash_nxt  = h_r;
          out_err_nxt   = err_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      base_r      <= BASE_RESET;
      len_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      base_r      <= base_nxt;
      len_r       <= len_nxt;
    end
    idx_r      <= idx_nxt;
    end_r      <= end_nxt;
    h_r        <= h_nxt;
    acc_r      <= acc_nxt;
    mul_r      <= mul_nxt;
    err_r      <= err_nxt;
    out_hash_r <= out_hash_nxt;
    out_err_r  <= out_err_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-HASH_W){1'b0}}, out_hash_r};
  assign out_tuser  = out_err_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_LENGTH) ? CFG_DW'(len_r) : CFG_DW'(base_r);

endmodule : substring_rolling_hash_core

`default_nettype wire

>>> src/srh_ram.sv
// ---------------------------------------------------------------------------
// srh_ram: generic single-port-write, single-port-read memory
// One write and one read per cycle; the read data is registered.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : srh_ram

`default_nettype wire

>>> src/srh_checker.sv
// ---------------------------------------------------------------------------
// srh_checker: port-level checks of the substring rolling hash core
// Watches the stream ports and flags illegal behavior.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srh_checker
  import srh_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tvalid,
  input wire logic                   in_tready,
  input wire logic                   in_tuser,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata,
  input wire logic                   out_tuser
);

  // A result that is not taken stays offered unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // An error result carries a zero hash.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("range error with nonzero hash");

  // The hash is fully reduced modulo 2^61-1.
  a_hash_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_TDATA_W-1:HASH_W] == '0 && out_tdata[HASH_W-1:0] != HASH_MOD)
    else $error("hash not reduced");

  // A write transfer never produces a result.
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == KIND_WRITE && !out_tvalid |=> !out_tvalid)
    else $error("result after a write");

endmodule : srh_checker

bind substring_rolling_hash_core srh_checker u_srh_checker (.*);

`default_nettype wire

>>> dv/substring_rolling_hash_checker.sv
// ---------------------------------------------------------------------------
// substring_rolling_hash_checker: result predictor for the rolling hash core
// Follows register writes and input transfers, works out the hash of each
// query and compares every result transfer with the oldest prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module substring_rolling_hash_checker
  import srh_pkg::*;
#(
  parameter int MAX_LENGTH = 1024
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   out_tuser,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_AW-1:0]      cfg_paddr,
  input  logic [CFG_DW-1:0]      cfg_pwdata,
  input  logic                   cfg_pready,
  output int                     mismatch_count,
  output int                     hashes_pending
);

  typedef struct packed {
    logic              range_error;
    logic [HASH_W-1:0] hash_value;
  } hash_result_t;

  hash_result_t        expected_hashes[$];
  logic [BASE_W-1:0]   base_reg = BASE_RESET;
  logic [POS_W-1:0]    length_reg = '0;
  logic [LETTER_W-1:0] letters[MAX_LENGTH];

  initial begin
    mismatch_count = 0;
    hashes_pending = 0;
    for (int i = 0; i < MAX_LENGTH; i++) letters[i] = '0;
  end

  // One Horner step, h*b + addend folded modulo 2^61-1.
  function automatic logic [HASH_W-1:0] horner_step(input logic [HASH_W-1:0] h,
                                                    input logic [BASE_W-1:0] b,
                                                    input logic [5:0] addend);
    logic [HASH_W+BASE_W:0] prod;
    logic [HASH_W:0]        folded;
    prod = h * b + addend;
    folded = prod[HASH_W-1:0] + prod[HASH_W+BASE_W:HASH_W];
    if (folded >= HASH_MOD) folded = folded - HASH_MOD;
    return folded[HASH_W-1:0];
  endfunction

  function automatic int store_length();
    return (length_reg > MAX_LENGTH) ? MAX_LENGTH : int'(length_reg);
  endfunction

  function automatic hash_result_t predict_query(input int first, input int stop_pos);
    hash_result_t r;
    logic [HASH_W-1:0] h;
    r.hash_value = '0;
    r.range_error = 1'b0;
    if (first > stop_pos || stop_pos > store_length()) begin
      r.range_error = 1'b1;
      return r;
    end
    h = '0;
    for (int i = first; i < stop_pos; i++) h = horner_step(h, base_reg, {1'b0, letters[i]} + 6'd1);
    r.hash_value = h;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] expected_val,
                                 input logic [63:0] actual_val);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("MISMATCH %s: expected %0h, got %0h", what, expected_val, actual_val);
  endtask

  always @(posedge clk) begin
    int           pos;
    int           stop_pos;
    hash_result_t want;
    if (!rst_n) begin
      base_reg = BASE_RESET;
      length_reg = '0;
      expected_hashes.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[2])
          REG_BASE:   base_reg = cfg_pwdata[BASE_W-1:0];
          REG_LENGTH: length_reg = cfg_pwdata[POS_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        pos = int'(in_tdata[POS_W-1:0]);
        stop_pos = int'(in_tdata[2*POS_W-1:POS_W]);
        if (in_tuser == KIND_WRITE) begin
          if (pos < store_length()) letters[pos] = in_tdata[2*POS_W+LETTER_W-1:2*POS_W];
        end else begin
          expected_hashes.push_back(predict_query(pos, stop_pos));
        end
      end
      if (out_tvalid && out_tready) begin
        if (expected_hashes.size() == 0) begin
          report_mismatch("unexpected result", '0, out_tdata);
        end else begin
          want = expected_hashes.pop_front();
          if (out_tdata[HASH_W-1:0] !== want.hash_value)
            report_mismatch("hash_value", 64'(want.hash_value), 64'(out_tdata[HASH_W-1:0]));
          if (out_tuser !== want.range_error)
            report_mismatch("range_error", 64'(want.range_error), 64'(out_tuser));
        end
      end
    end
    hashes_pending = expected_hashes.size();
  end

endmodule

>>> dv/substring_rolling_hash_core_test.sv
// ---------------------------------------------------------------------------
// substring_rolling_hash_core_test: stimulus and verdict for the hash core
// Loads letters, issues range queries under several base and length
// settings with random idling on both streams, and leaves prediction and
// comparison to the checker instantiated beside the core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module substring_rolling_hash_core_test;
  import srh_pkg::*;

  localparam int STORE_DEPTH   = 1024;
  // A write is stored at the edge where it transfers, so a short pause covers any write still in
  // flight once the last result has been taken.
  localparam int SETTLE_CYCLES = 8;
  // Long receiver hold-off used to back the core up into its input.
  localparam int HOLD_CYCLES   = 500;
  // The limit covers every item being a query over the full store, and more.
  localparam int CYCLE_LIMIT   = 10000000;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = KIND_WRITE;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   cfg_psel = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0]      cfg_paddr = '0;
  logic [CFG_DW-1:0]      cfg_pwdata = '0;
  logic [CFG_DW-1:0]      cfg_prdata;
  logic                   cfg_pready;

  int mismatch_count;
  int hashes_pending;

  // Stimulus-side view of the store: which entries hold a letter, and the
  // effective string length. Queries are only built over written entries.
  bit written_mask[STORE_DEPTH];
  int eff_len = 0;
  int items_sent = 0;
  int cycle_count = 0;

  // Idle percentages of the two streams. The receiver one is read by its
  // own process, so it is only changed with nonblocking assignments.
  int tx_idle_pct = 17;
  int rx_idle_pct = 67;

  // Each increment of hold_token asks the receiver process for one hold-off.
  int hold_token = 0;
  int hold_seen = 0;
  int hold_left = 0;

  always #2 clk = ~clk;

  substring_rolling_hash_core #(
    .MAX_LENGTH(STORE_DEPTH)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  substring_rolling_hash_checker #(
    .MAX_LENGTH(STORE_DEPTH)
  ) hash_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_pready    (cfg_pready),
    .mismatch_count(mismatch_count),
    .hashes_pending(hashes_pending)
  );

  // Result receiver. A requested hold-off keeps tready low for a long
  // stretch; otherwise tready follows the current idle percentage.
  always @(posedge clk) begin
    if (hold_seen != hold_token) begin
      hold_seen <= hold_token;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Watchdog: a hung core or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Mostly real letters, now and then a value above 'z' so that the top
  // bits of the letter field are exercised.
  function automatic int rand_letter();
    return ($urandom_range(7) == 0) ? $urandom_range(31, 26) : $urandom_range(25);
  endfunction

  // Offers one item after a random number of idle cycles and returns at the
  // edge where it transfers. While idle, tdata carries junk.
  task automatic send_item(input logic kind, input int pos, input int stop_pos,
                           input int letter);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata <= $urandom();
      in_tuser <= 1'($urandom_range(1));
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {5'b0, LETTER_W'(letter), POS_W'(stop_pos), POS_W'(pos)};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    if (kind == KIND_WRITE && pos < eff_len) written_mask[pos] = 1'b1;
  endtask

  // Query that starts at the given position and runs over written entries
  // only, up to max_span letters; it may come out empty.
  task automatic send_valid_query(input int start, input int max_span);
    int stop_pos;
    int span;
    span = $urandom_range(max_span);
    stop_pos = start;
    while (stop_pos < eff_len && stop_pos - start < span && written_mask[stop_pos])
      stop_pos++;
    send_item(KIND_QUERY, start, stop_pos, rand_letter());
  endtask

  // Lowers tvalid and waits until every predicted result has been taken.
  // The first edge lets the checker record a query that transferred just now.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (hashes_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle until pready.
  task automatic cfg_write(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic write_length(input logic [CFG_DW-1:0] length_word);
    cfg_write({REG_LENGTH, 2'b00}, length_word);
    eff_len = (length_word[POS_W-1:0] > STORE_DEPTH) ? STORE_DEPTH
                                                     : int'(length_word[POS_W-1:0]);
  endtask

  task automatic set_config(input logic [CFG_DW-1:0] base_word,
                            input logic [CFG_DW-1:0] length_word);
    drain_results();
    cfg_write({REG_BASE, 2'b00}, base_word);
    write_length(length_word);
  endtask

  // One piece of random traffic. Most of the time a run of letters is
  // written and then queried; otherwise a stray write or a query that
  // reads nothing (empty or bad range).
  task automatic run_burst();
    int run_start;
    int run_len;
    int stop_pos;
    if (eff_len > 0 && $urandom_range(4) != 0) begin
      run_len = ($urandom_range(24) == 0) ? $urandom_range(160, 32) : $urandom_range(12, 1);
      run_start = $urandom_range(eff_len - 1);
      for (int p = run_start; p < run_start + run_len && p < eff_len; p++)
        send_item(KIND_WRITE, p, $urandom_range(2047), rand_letter());
      // A few long queries reach across large written regions.
      send_valid_query($urandom_range(run_start + run_len - 1, run_start),
                       ($urandom_range(19) == 0) ? STORE_DEPTH : 16);
      repeat ($urandom_range(2)) send_valid_query($urandom_range(eff_len), 16);
    end else begin
      case ($urandom_range(3))
        0: send_item(KIND_WRITE, $urandom_range(2047), $urandom_range(2047), rand_letter());
        1: begin
          // Start beyond end.
          stop_pos = $urandom_range(2046);
          send_item(KIND_QUERY, $urandom_range(2047, stop_pos + 1), stop_pos, rand_letter());
        end
        2: send_item(KIND_QUERY, $urandom_range(2047), $urandom_range(2047, eff_len + 1),
                     rand_letter());
        default: begin
          stop_pos = $urandom_range(2047);
          send_item(KIND_QUERY, stop_pos, stop_pos, rand_letter());
        end
      endcase
    end
  endtask

  initial begin
    int phase_goal;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset state: length 0, so only the empty range at zero is valid and
    // writes are dropped.
    send_item(KIND_QUERY, 0, 0, 0);
    send_item(KIND_QUERY, 0, 1, 0);
    send_item(KIND_WRITE, 0, 0, 7);

    // Full store with the reset base; letters at both ends of the store.
    drain_results();
    write_length(STORE_DEPTH);
    send_item(KIND_WRITE, 0, 2047, 0);
    send_item(KIND_WRITE, 1, 0, 25);
    send_item(KIND_WRITE, 2, 0, 31);
    send_item(KIND_WRITE, 1022, 0, 1);
    send_item(KIND_WRITE, 1023, 0, 26);
    send_item(KIND_WRITE, 1024, 0, 5);
    send_item(KIND_WRITE, 2047, 2047, 31);
    send_item(KIND_QUERY, 0, 3, 0);
    send_item(KIND_QUERY, 2, 3, 31);
    send_item(KIND_QUERY, 1023, 1024, 0);
    send_item(KIND_QUERY, 1022, 1024, 0);
    send_item(KIND_QUERY, 1024, 1024, 0);
    send_item(KIND_QUERY, 2, 1, 0);
    send_item(KIND_QUERY, 0, 1025, 0);
    send_item(KIND_QUERY, 2047, 2047, 0);
    send_item(KIND_QUERY, 2047, 0, 0);

    // Largest base (upper data bits are dropped by the register).
    set_config(32'hFFFF_FFFF, STORE_DEPTH);
    send_item(KIND_QUERY, 0, 3, 0);
    send_item(KIND_QUERY, 1022, 1024, 0);

    // Base zero keeps only the last letter; a length above the store
    // saturates to the store depth.
    set_config(32'd0, 32'hFFFF_FFFF);
    send_item(KIND_QUERY, 0, 3, 0);
    send_item(KIND_QUERY, 1023, 1025, 0);
    send_item(KIND_QUERY, 1022, 1024, 0);

    for (int phase = 0; phase < 9; phase++) begin
      case (phase)
        0: set_config($urandom_range(1000000000, 414123123), STORE_DEPTH);
        1: set_config(BASE_RESET, $urandom_range(STORE_DEPTH, 1));
        2: set_config(32'd1, 32'd1);
        3: set_config($urandom(), STORE_DEPTH);
        4: set_config(32'd1000000000, 32'hFFFF_F800 | $urandom_range(2047, 1025));
        5: set_config(32'd0, 32'd64);
        6: set_config({2'b00, {BASE_W{1'b1}}}, STORE_DEPTH);
        7: set_config($urandom_range(1000000000, 414123123), 32'd0);
        default: set_config($urandom(), STORE_DEPTH);
      endcase

      if (phase < 3) begin
        tx_idle_pct = 17;
        rx_idle_pct <= 67;
      end else if (phase < 6) begin
        tx_idle_pct = 67;
        rx_idle_pct <= 17;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
      end

      // Back-pressure: the receiver stops for a long while and the sender
      // keeps offering short queries until the core stalls its input.
      if (phase == 6) begin
        hold_token <= hold_token + 1;
        repeat (12) send_valid_query($urandom_range(eff_len), 4);
      end

      phase_goal = items_sent + ((eff_len == 0) ? 24 : 60);
      while (items_sent < phase_goal) run_burst();
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && hashes_pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> substring_rolling_hash_core.f
src/srh_pkg.sv
src/srh_ram.sv
src/substring_rolling_hash_core.sv
src/srh_checker.sv
dv/substring_rolling_hash_checker.sv
dv/substring_rolling_hash_core_test.sv
